FILE: rtl/core/lmcf_pkg.sv
// Shared types and constants for the letter multiset containment filter.
package lmcf_pkg;

	localparam int unsigned ALPHABET_SIZE     = 26;
	localparam int unsigned COUNT_MAX_DEFAULT = 15;
	localparam int unsigned IDX_W             = $clog2(ALPHABET_SIZE);
	localparam logic [7:0]  LETTER_FIRST      = 8'h61;
	localparam logic [7:0]  LETTER_LAST       = 8'h7A;
	localparam int unsigned S_TDATA_W         = 8;
	localparam int unsigned S_TUSER_W         = 2;
	localparam int unsigned M_TDATA_W         = 8;

	typedef enum logic [1:0] {
		CMD_PATTERN   = 2'd0,
		CMD_CANDIDATE = 2'd1,
		CMD_CLEAR     = 2'd2
	} cmd_t;

	// one character travelling down the cell chain
	typedef struct packed {
		logic             vld;
		cmd_t             cmd;
		logic             letter;
		logic [IDX_W-1:0] idx;
		logic             word_end;
		logic             ok;
	} item_t;

endpackage

FILE: rtl/core/lmcf_cell.sv
// One letter cell: word count and requirement for a single letter.
module lmcf_cell #(
	parameter int unsigned COUNT_MAX  = lmcf_pkg::COUNT_MAX_DEFAULT,
	parameter int unsigned CELL_INDEX = 0
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           adv,
	input  lmcf_pkg::item_t item_in,
	output lmcf_pkg::item_t item_out
);
	import lmcf_pkg::*;

	localparam int unsigned CW = $clog2(COUNT_MAX + 1);
	localparam logic [CW-1:0] CNT_MAX = CW'(COUNT_MAX);
	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_INDEX);

	logic [CW-1:0] cnt_q, req_q;
	logic [CW-1:0] cnt_inc, cnt_d, req_d;
	logic          hit, ok_d;
	item_t         item_s1;

	assign hit     = item_in.letter && (item_in.idx == MY_IDX);
	assign cnt_inc = (hit && (cnt_q < CNT_MAX)) ? cnt_q + CW'(1) : cnt_q;

	always_comb begin
		cnt_d = cnt_q;
		req_d = req_q;
		ok_d  = item_in.ok;
		if (item_in.vld) begin
			unique case (item_in.cmd)
				CMD_CLEAR: begin
					req_d = '0;
				end
				CMD_PATTERN: begin
					cnt_d = cnt_inc;
					if (item_in.word_end) begin
						cnt_d = '0;
						if (cnt_inc > req_q) req_d = cnt_inc;
					end
				end
				CMD_CANDIDATE: begin
					cnt_d = cnt_inc;
					if (item_in.word_end) begin
						cnt_d = '0;
						ok_d  = item_in.ok && (cnt_inc >= req_q);
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			req_q   <= '0;
			item_s1 <= '0;
		end else if (adv) begin
			cnt_q            <= cnt_d;
			req_q            <= req_d;
			item_s1.vld      <= item_in.vld;
			item_s1.cmd      <= item_in.cmd;
			item_s1.letter   <= item_in.letter;
			item_s1.idx      <= item_in.idx;
			item_s1.word_end <= item_in.word_end;
			item_s1.ok       <= ok_d;
		end
	end

	assign item_out = item_s1;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= CNT_MAX)
		else $error("word count above bound");
	a_req_bound: assert property (@(posedge clk) disable iff (!arst_n) req_q <= CNT_MAX)
		else $error("requirement above bound");
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && item_in.vld && item_in.cmd == CMD_CLEAR) |=> (req_q == '0))
		else $error("clear did not zero requirement");

endmodule

FILE: rtl/core/letter_multiset_containment_filter_top.sv
// Letter multiset containment filter: chain of 26 letter cells and output register.
// Takes one character per cycle while the chain is not stalled. Each character walks
// a chain of 26 cells, one per letter, and the pass/fail flag builds up as it goes;
// a candidate word's flag passes the 26 cell registers and then the output register.
// The whole chain stalls only while a result sits at its end and the output register
// still holds an untaken result.
module letter_multiset_containment_filter_top #(
	parameter int unsigned COUNT_MAX = lmcf_pkg::COUNT_MAX_DEFAULT
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	input  logic [lmcf_pkg::S_TDATA_W-1:0]   s_axis_tdata,  // [7:0] char_code
	input  logic [lmcf_pkg::S_TUSER_W-1:0]   s_axis_tuser,  // [1:0] cmd
	input  logic                             s_axis_tlast,  // word_end
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	output logic [lmcf_pkg::M_TDATA_W-1:0]   m_axis_tdata   // [0] accepted
);
	import lmcf_pkg::*;

	item_t      chain [0:ALPHABET_SIZE];
	logic [7:0] char_code;
	logic       adv, res_at_end;
	logic       out_valid_q, accepted_q;

	assign char_code = s_axis_tdata[7:0];

	always_comb begin
		chain[0].vld      = s_axis_tvalid;
		chain[0].cmd      = cmd_t'(s_axis_tuser[1:0]);
		chain[0].letter   = (char_code >= LETTER_FIRST) && (char_code <= LETTER_LAST);
		chain[0].idx      = IDX_W'(char_code - LETTER_FIRST);
		chain[0].word_end = s_axis_tlast;
		chain[0].ok       = 1'b1;
	end

	for (genvar g = 0; g < ALPHABET_SIZE; g++) begin : g_cell
		lmcf_cell #(
			.COUNT_MAX (COUNT_MAX),
			.CELL_INDEX(g)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.adv     (adv),
			.item_in (chain[g]),
			.item_out(chain[g+1])
		);
	end

	assign res_at_end = chain[ALPHABET_SIZE].vld && chain[ALPHABET_SIZE].word_end
		&& (chain[ALPHABET_SIZE].cmd == CMD_CANDIDATE);
	assign adv = !res_at_end || !out_valid_q || m_axis_tready;
	assign s_axis_tready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && res_at_end) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && res_at_end) accepted_q <= chain[ALPHABET_SIZE].ok;
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(M_TDATA_W-1){1'b0}}, accepted_q};

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> (m_axis_tvalid && res_at_end))
		else $error("input stalled without a pending result");
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(res_at_end))
		else $error("result without candidate word end");
	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !m_axis_tready && res_at_end) |=> out_valid_q)
		else $error("pending result lost");

endmodule

FILE: verif/letter_multiset_containment_filter_top_tb.sv
// Testbench for the letter multiset containment filter: streamed words checked against a predictor.
`timescale 1ns / 100ps

module letter_multiset_containment_filter_top_tb;
	import lmcf_pkg::*;

	localparam int unsigned COUNT_MAX    = COUNT_MAX_DEFAULT;
	localparam int unsigned CNT_W        = $clog2(COUNT_MAX + 1);
	localparam int          CLK_PERIOD   = 8;
	localparam int          ITEMS_TARGET = 650;
	localparam int          HOLD_CYCLES  = 400;
	localparam int          DRAIN_CYCLES = 64;
	localparam int          CYCLE_LIMIT  = 400000;
	localparam logic [1:0]  CMD_UNUSED   = 2'd3;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 s_axis_tvalid;
	logic                 s_axis_tready;
	logic [S_TDATA_W-1:0] s_axis_tdata;
	logic [S_TUSER_W-1:0] s_axis_tuser;
	logic                 s_axis_tlast;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready;
	logic [M_TDATA_W-1:0] m_axis_tdata;

	logic [CNT_W-1:0] word_tally [ALPHABET_SIZE];
	logic [CNT_W-1:0] need_tally [ALPHABET_SIZE];
	logic             verdict_q [$];

	bit src_idle    = 1'b1;
	bit sink_idle   = 1'b1;
	int hold_left   = 0;
	int mismatches  = 0;
	int chars_sent  = 0;
	int clears_sent = 0;
	int met         = 0;
	int missed      = 0;
	int verdicts_in = 0;

	letter_multiset_containment_filter_top #(
		.COUNT_MAX(COUNT_MAX)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	function automatic int pick_gap(input bit enabled);
		int r;
		r = $urandom_range(0, 99);
		if (!enabled || r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(4, 30);
	endfunction

	function automatic logic [7:0] pick_char();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return 8'(LETTER_FIRST + $urandom_range(0, 3));
		if (r < 90)
			return 8'(LETTER_FIRST + $urandom_range(0, ALPHABET_SIZE - 1));
		return 8'($urandom_range(0, 255));
	endfunction

	// returns 1 when the character closes a candidate word; verdict then holds the flag
	function automatic logic predict_step(input logic [1:0] cmd, input logic [7:0] code,
		input logic last, output logic verdict);
		logic [IDX_W-1:0] slot;
		int               i;
		verdict = 1'b1;
		if (cmd == CMD_CLEAR) begin
			foreach (need_tally[j])
				need_tally[j] = '0;
			return 1'b0;
		end
		if (cmd == CMD_UNUSED)
			return 1'b0;
		if (code >= LETTER_FIRST && code <= LETTER_LAST) begin
			slot = IDX_W'(code - LETTER_FIRST);
			if (word_tally[slot] < COUNT_MAX)
				word_tally[slot]++;
		end
		if (!last)
			return 1'b0;
		for (i = 0; i < ALPHABET_SIZE; i++) begin
			if (cmd == CMD_PATTERN) begin
				if (word_tally[i] > need_tally[i])
					need_tally[i] = word_tally[i];
			end else if (word_tally[i] < need_tally[i]) begin
				verdict = 1'b0;
			end
			word_tally[i] = '0;
		end
		return cmd == CMD_CANDIDATE;
	endfunction

	task automatic log_mismatch(input string what);
		$display("[%0t] mismatch: %s", $time, what);
		mismatches++;
	endtask

	task automatic take_verdict(input logic got);
		logic want;
		verdicts_in++;
		if (verdict_q.size() == 0) begin
			log_mismatch($sformatf("verdict %0b with no candidate word pending", got));
			return;
		end
		want = verdict_q.pop_front();
		if (got !== want)
			log_mismatch($sformatf("verdict #%0d: accepted %0b, want %0b",
				verdicts_in, got, want));
	endtask

	task automatic send_char(input logic [1:0] cmd, input logic [7:0] code, input logic last);
		logic verdict;
		int   gap;
		gap = pick_gap(src_idle);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= code;
		s_axis_tuser  <= cmd;
		s_axis_tlast  <= last;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		if (predict_step(cmd, code, last, verdict)) begin
			verdict_q = {verdict_q, verdict};
			if (verdict)
				met++;
			else
				missed++;
		end
		if (cmd == CMD_CLEAR)
			clears_sent++;
		chars_sent++;
	endtask

	task automatic test_directed();
		send_char(CMD_CANDIDATE, "a", 1'b1);
		send_char(CMD_CANDIDATE, 8'h00, 1'b1);
		send_char(CMD_PATTERN, "a", 1'b0);
		send_char(CMD_PATTERN, "a", 1'b1);
		send_char(CMD_CANDIDATE, "a", 1'b1);
		// bytes just outside the letter range are skipped
		send_char(CMD_CANDIDATE, 8'h60, 1'b0);
		send_char(CMD_CANDIDATE, "a", 1'b0);
		send_char(CMD_CANDIDATE, 8'h7B, 1'b0);
		send_char(CMD_CANDIDATE, 8'hFF, 1'b0);
		send_char(CMD_CANDIDATE, "a", 1'b1);
		send_char(CMD_PATTERN, "z", 1'b1);
		// mixed word, last command decides
		send_char(CMD_PATTERN, "a", 1'b0);
		send_char(CMD_CANDIDATE, "a", 1'b0);
		send_char(CMD_CANDIDATE, "z", 1'b1);
		send_char(CMD_CANDIDATE, "a", 1'b0);
		send_char(CMD_UNUSED, "a", 1'b1);
		send_char(CMD_CANDIDATE, "z", 1'b1);
		// clear mid-word keeps the word counts
		send_char(CMD_CANDIDATE, "a", 1'b0);
		send_char(CMD_CLEAR, 8'hFF, 1'b1);
		send_char(CMD_CANDIDATE, "z", 1'b1);
		send_char(CMD_CANDIDATE, "a", 1'b0);
		send_char(CMD_PATTERN, "b", 1'b1);
		send_char(CMD_CANDIDATE, "b", 1'b1);
		send_char(CMD_CLEAR, 8'h00, 1'b0);
		send_char(CMD_CANDIDATE, "b", 1'b1);
	endtask

	task automatic test_backpressure();
		int k;
		src_idle  = 1'b0;
		hold_left = HOLD_CYCLES;
		for (k = 0; k < 60; k++)
			send_char(CMD_CANDIDATE, pick_char(), 1'b1);
		src_idle = 1'b1;
	endtask

	task automatic test_random_words(input int target);
		int         len;
		int         k;
		int         kind;
		bit         mixed;
		bit         run;
		logic [1:0] wcmd;
		logic [1:0] ccmd;
		logic [7:0] run_letter;
		logic [7:0] code;
		while (chars_sent < target) begin
			if ($urandom_range(0, 24) == 0) begin
				src_idle  = 1'($urandom_range(0, 1));
				sink_idle = 1'($urandom_range(0, 1));
			end
			kind = $urandom_range(0, 99);
			if (kind < 8) begin
				send_char(CMD_CLEAR, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
			end else if (kind < 14) begin
				send_char(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
					1'($urandom_range(0, 1)));
			end else begin
				wcmd  = (kind < 50) ? CMD_PATTERN : CMD_CANDIDATE;
				mixed = ($urandom_range(0, 9) == 0);
				run   = ($urandom_range(0, 11) == 0);
				if (run)
					len = $urandom_range(13, 18);
				else if ($urandom_range(0, 4) == 0)
					len = $urandom_range(5, 10);
				else
					len = $urandom_range(1, 4);
				run_letter = 8'(LETTER_FIRST + $urandom_range(0, 2));
				for (k = 0; k < len; k++) begin
					code = run ? run_letter : pick_char();
					ccmd = (mixed && k < len - 1) ? 2'($urandom_range(0, 1)) : wcmd;
					send_char(ccmd, code, k == len - 1);
				end
			end
		end
	endtask

	initial begin : sink
		int stall;
		stall = 0;
		m_axis_tready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready)
				take_verdict(m_axis_tdata[0]);
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else if (stall > 0) begin
				stall--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
				stall = pick_gap(sink_idle);
			end
		end
	end

	initial begin : watchdog
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Timeout after %0d cycles, %0d verdicts pending", cycles, verdict_q.size());
		$display("*** FAILED ***");
		$finish;
	end

	initial begin
		foreach (word_tally[i])
			word_tally[i] = '0;
		foreach (need_tally[i])
			need_tally[i] = '0;
		arst_n        <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		s_axis_tuser  <= '0;
		s_axis_tlast  <= 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_backpressure();
		test_random_words(ITEMS_TARGET);
		s_axis_tvalid <= 1'b0;

		while (verdict_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d characters with %0d table clears; %0d candidate verdicts",
			chars_sent, clears_sent, met + missed);
		$display("(%0d met, %0d missed), incl. saturating runs, mixed words and a %0d-cycle hold.",
			met, missed, HOLD_CYCLES);
		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
